// ----- hw/rtl/dpfrc_pkg.sv -----
// ----------------------------------------------------------------------------
// dpfrc_pkg
// Types and constants shared by the packet FIFO with duplicate filter.
// ----------------------------------------------------------------------------
package dpfrc_pkg;

  localparam int SRC_W   = 16;
  localparam int DST_W   = 16;
  localparam int TS_W    = 30;
  localparam int ACT_W   = 2;
  localparam int LIMIT_W = 5;
  localparam int MATCH_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [ACT_W-1:0] ACT_ADD     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COUNT   = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [SRC_W-1:0] source;
    logic [DST_W-1:0] destination;
    logic [TS_W-1:0]  timestamp;
    logic [TS_W-1:0]  start_time;
    logic [TS_W-1:0]  end_time;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic               valid_res;
    logic [SRC_W-1:0]   out_source;
    logic [DST_W-1:0]   out_destination;
    logic [TS_W-1:0]    out_timestamp;
    logic [MATCH_W-1:0] match_count;
  } res_t;

  typedef struct packed {
    logic [SRC_W-1:0] source;
    logic [DST_W-1:0] destination;
    logic [TS_W-1:0]  tstamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

// ----- hw/rtl/dedup_packet_fifo_with_range_count.sv -----
// ----------------------------------------------------------------------------
// dedup_packet_fifo_with_range_count
// Bounded packet FIFO: add with duplicate filter, forward oldest, range count.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. busy then stays high
// through the scan, drain and finish states; the scan reads every held entry
// on an add or count request, the oldest entry on a forward from a non-empty
// queue, and no entry on an empty one or on any other action. A new request
// can be taken as soon as busy is low. Request spacing is set by the single
// read port of the entry store, which the sequencer walks one held entry per
// cycle through one shared compare unit, oldest first. The result appears on
// res, marked by done for exactly one cycle, in the first cycle with busy low;
// it must be taken then, as it cannot be held off. memory_limit is written
// through the cfg channel, which is always ready; the user must write it only
// while no request is in progress, as the block itself does not enforce it.
module dedup_packet_fifo_with_range_count #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  dpfrc_pkg::req_t               req,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dpfrc_pkg::LIMIT_W-1:0] cfg_data,
  output logic                          done,
  output dpfrc_pkg::res_t               res
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (OCC_W > dpfrc_pkg::LIMIT_W) ? OCC_W : dpfrc_pkg::LIMIT_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  dpfrc_pkg::entry_t mem [DEPTH];
  dpfrc_pkg::entry_t rd_data;

  dpfrc_pkg::state_t state, state_next;
  dpfrc_pkg::req_t   cur;

  logic [dpfrc_pkg::LIMIT_W-1:0] mem_limit;
  logic [PTR_W-1:0] head, tail, scan_addr;
  logic [OCC_W-1:0] occ, scan_idx, scan_len, cnt;
  logic             rd_vld, dup;

  logic             accept, issue_rd, scan_end, finish;
  logic             hit_full, hit_range;
  logic [CMP_W-1:0] lim_eff, occ_ext;
  logic             at_limit, store;
  logic [OCC_W-1:0] len_sel;
  dpfrc_pkg::res_t  res_next;

  assign busy      = (state != dpfrc_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign scan_end  = (scan_idx == scan_len);

  // Shared compare unit
  assign hit_full  = (rd_data.source == cur.source) &&
                     (rd_data.destination == cur.destination) &&
                     (rd_data.tstamp == cur.timestamp);
  assign hit_range = (rd_data.destination == cur.destination) &&
                     (rd_data.tstamp >= cur.start_time) &&
                     (rd_data.tstamp <= cur.end_time);

  always_comb begin
    unique case (req.action) inside
      dpfrc_pkg::ACT_ADD,
      dpfrc_pkg::ACT_COUNT:   len_sel = occ;
      dpfrc_pkg::ACT_FORWARD: len_sel = (occ != '0) ? OCC_W'(1) : '0;
      default:                len_sel = '0;
    endcase
  end

  always_comb begin
    lim_eff = CMP_W'(mem_limit);
    if (lim_eff == '0) lim_eff = CMP_W'(1);
    if (lim_eff > CMP_W'(DEPTH)) lim_eff = CMP_W'(DEPTH);
    occ_ext  = CMP_W'(occ);
    at_limit = (occ_ext >= lim_eff);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dpfrc_pkg::ST_IDLE:   if (accept) state_next = dpfrc_pkg::ST_SCAN;
      dpfrc_pkg::ST_SCAN:   if (scan_end) state_next = dpfrc_pkg::ST_DRAIN;
      dpfrc_pkg::ST_DRAIN:  state_next = dpfrc_pkg::ST_FINISH;
      dpfrc_pkg::ST_FINISH: state_next = dpfrc_pkg::ST_IDLE;
      default:              state_next = dpfrc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    issue_rd = 1'b0;
    finish   = 1'b0;
    unique case (state)
      dpfrc_pkg::ST_SCAN:   issue_rd = !scan_end;
      dpfrc_pkg::ST_FINISH: finish   = 1'b1;
      default: begin
        issue_rd = 1'b0;
        finish   = 1'b0;
      end
    endcase
  end

  assign store = finish && (cur.action == dpfrc_pkg::ACT_ADD) && !dup;

  always_comb begin
    res_next = '0;
    case (cur.action)
      dpfrc_pkg::ACT_ADD: res_next.accepted = !dup;
      dpfrc_pkg::ACT_FORWARD: begin
        if (occ != '0) begin
          res_next.valid_res       = 1'b1;
          res_next.out_source      = rd_data.source;
          res_next.out_destination = rd_data.destination;
          res_next.out_timestamp   = rd_data.tstamp;
        end
      end
      dpfrc_pkg::ACT_COUNT: res_next.match_count = dpfrc_pkg::MATCH_W'(cnt);
      default: res_next = '0;
    endcase
  end

  // Entry store, one read port
  always_ff @(posedge clk) begin
    if (issue_rd) begin
      rd_data <= mem[scan_addr];
    end
    if (store) begin
      mem[tail] <= '{source: cur.source, destination: cur.destination,
                     tstamp: cur.timestamp};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dpfrc_pkg::ST_IDLE;
      mem_limit <= dpfrc_pkg::LIMIT_RESET;
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      rd_vld    <= 1'b0;
      done      <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue_rd;
      done   <= finish;
      if (cfg_valid && cfg_ready) begin
        mem_limit <= cfg_data;
      end
      if (finish) begin
        if (store) begin
          tail <= (tail == LAST_SLOT) ? '0 : tail + 1'b1;
          if (at_limit) begin
            head <= (head == LAST_SLOT) ? '0 : head + 1'b1;
          end else begin
            occ <= occ + 1'b1;
          end
        end else if ((cur.action == dpfrc_pkg::ACT_FORWARD) && (occ != '0)) begin
          head <= (head == LAST_SLOT) ? '0 : head + 1'b1;
          occ  <= occ - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur       <= req;
      scan_idx  <= '0;
      scan_len  <= len_sel;
      scan_addr <= head;
      cnt       <= '0;
      dup       <= 1'b0;
    end else begin
      if (issue_rd) begin
        scan_idx  <= scan_idx + 1'b1;
        scan_addr <= (scan_addr == LAST_SLOT) ? '0 : scan_addr + 1'b1;
      end
      if (rd_vld) begin
        if (hit_full)  dup <= 1'b1;
        if (hit_range) cnt <= cnt + 1'b1;
      end
    end
    if (finish) begin
      res <= res_next;
    end
  end

endmodule

// ----- hw/rtl/dpfrc_checker.sv -----
// ----------------------------------------------------------------------------
// dpfrc_checker
// Port-level checks on request sequencing and result encoding.
// ----------------------------------------------------------------------------
module dpfrc_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input dpfrc_pkg::res_t res
);

  a_take_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_fall_done : assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("request ended without a result");

  a_done_after : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe outside request completion");

  a_one_kind : assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({res.accepted, res.valid_res, res.match_count != '0}))
    else $error("result mixes fields of different actions");

  a_fwd_zero : assert property (@(posedge clk) disable iff (rst)
    done && !res.valid_res |-> (res.out_source == '0) &&
      (res.out_destination == '0) && (res.out_timestamp == '0))
    else $error("packet fields set without a forwarded packet");

endmodule

bind dedup_packet_fifo_with_range_count dpfrc_checker u_dpfrc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .res   (res)
);

// ----- verif/tb_dedup_packet_fifo_with_range_count.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dedup_packet_fifo_with_range_count
// Self-checking bench for the packet FIFO with duplicate filter and range
// count. A clocked driver feeds add, forward, count and spare requests plus
// memory_limit writes from a queue; a model of the store predicts each
// result and a clocked monitor checks every done strobe field by field.
// ----------------------------------------------------------------------------
module tb_dedup_packet_fifo_with_range_count;

  localparam int DEPTH = 16;
  localparam logic [dpfrc_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam logic [dpfrc_pkg::TS_W-1:0] TS_MAX = '1;

  typedef enum logic {OP_REQUEST, OP_LIMIT} op_kind_t;

  typedef struct {
    op_kind_t                        kind;
    dpfrc_pkg::req_t                 req;
    logic [dpfrc_pkg::LIMIT_W-1:0]   limit;
    int unsigned                     gap_pct;
  } packet_op_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  dpfrc_pkg::req_t               req = '0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [dpfrc_pkg::LIMIT_W-1:0] cfg_data = '0;
  logic                          done;
  dpfrc_pkg::res_t               res;

  packet_op_t                    packet_ops[$];
  dpfrc_pkg::res_t               due_results[$];
  int unsigned                   sender_gap;
  int unsigned                   mismatches = 0;

  // model state
  dpfrc_pkg::entry_t             held_pkt[DEPTH];
  int unsigned                   oldest = 0;
  int unsigned                   next_free = 0;
  int unsigned                   held = 0;
  logic [dpfrc_pkg::LIMIT_W-1:0] limit_reg = dpfrc_pkg::LIMIT_RESET;

  logic [dpfrc_pkg::SRC_W-1:0]   src_pool[4];
  logic [dpfrc_pkg::DST_W-1:0]   dst_pool[4];
  logic [dpfrc_pkg::TS_W-1:0]    ts_pool[6];

  dedup_packet_fifo_with_range_count #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .res       (res)
  );

  always #5 clk = ~clk;

  function automatic dpfrc_pkg::res_t packet_fifo_step(dpfrc_pkg::req_t r);
    dpfrc_pkg::res_t               o;
    bit                            dup;
    int unsigned                   cap;
    logic [dpfrc_pkg::MATCH_W-1:0] n;
    dpfrc_pkg::entry_t             e;
    o = '0;
    case (r.action)
      dpfrc_pkg::ACT_ADD: begin
        dup = 1'b0;
        for (int k = 0; k < held; k++) begin
          e = held_pkt[(oldest + k) % DEPTH];
          if (e.source == r.source && e.destination == r.destination &&
              e.tstamp == r.timestamp)
            dup = 1'b1;
        end
        if (!dup) begin
          cap = (limit_reg == 0) ? 1 : ((limit_reg > DEPTH) ? DEPTH : limit_reg);
          if (held >= cap) begin
            oldest = (oldest + 1) % DEPTH;
            held--;
          end
          held_pkt[next_free] = '{r.source, r.destination, r.timestamp};
          next_free = (next_free + 1) % DEPTH;
          held++;
          o.accepted = 1'b1;
        end
      end
      dpfrc_pkg::ACT_FORWARD: begin
        if (held != 0) begin
          e = held_pkt[oldest];
          o.valid_res = 1'b1;
          o.out_source = e.source;
          o.out_destination = e.destination;
          o.out_timestamp = e.tstamp;
          oldest = (oldest + 1) % DEPTH;
          held--;
        end
      end
      dpfrc_pkg::ACT_COUNT: begin
        n = '0;
        for (int k = 0; k < held; k++) begin
          e = held_pkt[(oldest + k) % DEPTH];
          if (e.destination == r.destination && e.tstamp >= r.start_time &&
              e.tstamp <= r.end_time)
            n++;
        end
        o.match_count = n;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic push_packet_op(logic [dpfrc_pkg::ACT_W-1:0] act,
                                logic [dpfrc_pkg::SRC_W-1:0] src,
                                logic [dpfrc_pkg::DST_W-1:0] dst,
                                logic [dpfrc_pkg::TS_W-1:0] ts,
                                logic [dpfrc_pkg::TS_W-1:0] lo,
                                logic [dpfrc_pkg::TS_W-1:0] hi);
    packet_op_t c;
    c.kind = OP_REQUEST;
    c.req = '{act, src, dst, ts, lo, hi};
    c.limit = '0;
    c.gap_pct = sender_gap;
    packet_ops.insert(packet_ops.size(), c);
  endtask

  task automatic push_limit_write(logic [dpfrc_pkg::LIMIT_W-1:0] v);
    packet_op_t c;
    c.kind = OP_LIMIT;
    c.req = '0;
    c.limit = v;
    c.gap_pct = 0;
    packet_ops.insert(packet_ops.size(), c);
  endtask

  task automatic refill_pools();
    for (int k = 0; k < 4; k++) begin
      src_pool[k] = dpfrc_pkg::SRC_W'($urandom);
      dst_pool[k] = dpfrc_pkg::DST_W'($urandom);
    end
    for (int k = 0; k < 6; k++)
      ts_pool[k] = dpfrc_pkg::TS_W'($urandom);
    if ($urandom_range(3) == 0) ts_pool[0] = '0;
    if ($urandom_range(3) == 0) ts_pool[1] = TS_MAX;
  endtask

  task automatic push_random_op();
    int unsigned                 pick;
    logic [dpfrc_pkg::TS_W-1:0]  a;
    logic [dpfrc_pkg::TS_W-1:0]  b;
    logic [dpfrc_pkg::ACT_W-1:0] act;
    logic [dpfrc_pkg::SRC_W-1:0] src;
    logic [dpfrc_pkg::DST_W-1:0] dst;
    logic [dpfrc_pkg::TS_W-1:0]  ts;
    logic [dpfrc_pkg::TS_W-1:0]  lo;
    logic [dpfrc_pkg::TS_W-1:0]  hi;
    pick = $urandom_range(99);
    act = (pick < 48) ? dpfrc_pkg::ACT_ADD : (pick < 68) ? dpfrc_pkg::ACT_FORWARD :
          (pick < 93) ? dpfrc_pkg::ACT_COUNT : ACT_SPARE;
    src = dpfrc_pkg::SRC_W'($urandom);
    dst = dpfrc_pkg::DST_W'($urandom);
    ts = dpfrc_pkg::TS_W'($urandom);
    lo = dpfrc_pkg::TS_W'($urandom);
    hi = dpfrc_pkg::TS_W'($urandom);
    // mostly reuse a small pool so duplicates and matches are common
    if ($urandom_range(3) != 0) begin
      src = src_pool[$urandom_range(3)];
      dst = dst_pool[$urandom_range(3)];
      ts = ts_pool[$urandom_range(5)];
    end
    case ($urandom_range(3))
      0: ;
      1: begin
        lo = '0;
        hi = TS_MAX;
      end
      default: begin
        a = ts_pool[$urandom_range(5)];
        b = ts_pool[$urandom_range(5)];
        if ((a <= b) == ($urandom_range(4) != 0)) begin
          lo = a;
          hi = b;
        end else begin
          lo = b;
          hi = a;
        end
      end
    endcase
    push_packet_op(act, src, dst, ts, lo, hi);
  endtask

  // driver
  always @(posedge clk) begin
    packet_op_t c;
    logic       nxt_start;
    logic       nxt_cfg;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_cfg = cfg_valid;
      if (start && !busy) begin
        due_results.insert(due_results.size(), packet_fifo_step(req));
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        limit_reg = cfg_data;
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg && packet_ops.size() != 0) begin
        c = packet_ops[0];
        if (c.kind == OP_REQUEST) begin
          if ($urandom_range(99) >= c.gap_pct) begin
            c = packet_ops.pop_front();
            req <= c.req;
            nxt_start = 1'b1;
          end
        end else if (due_results.size() == 0 && !done) begin
          // limit writes only once every request has completed
          c = packet_ops.pop_front();
          cfg_data <= c.limit;
          nxt_cfg = 1'b1;
        end
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // monitor
  always @(posedge clk) begin
    dpfrc_pkg::res_t want;
    if (!rst && done) begin
      if (due_results.size() == 0) begin
        flag_mismatch("result strobe with no request outstanding");
      end else begin
        want = due_results.pop_front();
        if (res.accepted !== want.accepted)
          flag_mismatch($sformatf("accepted %0b, want %0b", res.accepted, want.accepted));
        if (res.valid_res !== want.valid_res)
          flag_mismatch($sformatf("valid_res %0b, want %0b", res.valid_res, want.valid_res));
        if (res.out_source !== want.out_source)
          flag_mismatch($sformatf("out_source %h, want %h", res.out_source,
                                  want.out_source));
        if (res.out_destination !== want.out_destination)
          flag_mismatch($sformatf("out_destination %h, want %h", res.out_destination,
                                  want.out_destination));
        if (res.out_timestamp !== want.out_timestamp)
          flag_mismatch($sformatf("out_timestamp %h, want %h", res.out_timestamp,
                                  want.out_timestamp));
        if (res.match_count !== want.match_count)
          flag_mismatch($sformatf("match_count %0d, want %0d", res.match_count,
                                  want.match_count));
      end
    end
  end

  initial begin
    logic [dpfrc_pkg::LIMIT_W-1:0] lim;
    int unsigned                   gaps[3];
    gaps = '{7, 67, 0};
    sender_gap = gaps[0];

    // directed: empty queue, spare action, extremes, duplicates, ranges
    push_packet_op(dpfrc_pkg::ACT_COUNT, '0, '0, '0, '0, TS_MAX);
    push_packet_op(dpfrc_pkg::ACT_FORWARD, '0, '0, '0, '0, '0);
    push_packet_op(ACT_SPARE, '1, '1, TS_MAX, TS_MAX, TS_MAX);
    push_packet_op(dpfrc_pkg::ACT_ADD, '0, '0, '0, '0, '0);
    push_packet_op(dpfrc_pkg::ACT_ADD, '1, '1, TS_MAX, '0, '0);
    push_packet_op(dpfrc_pkg::ACT_ADD, '0, '0, '0, '0, '0);
    push_packet_op(dpfrc_pkg::ACT_ADD, 16'd1, '0, '0, '0, '0);
    push_packet_op(dpfrc_pkg::ACT_ADD, '0, 16'd1, '0, '0, '0);
    push_packet_op(dpfrc_pkg::ACT_ADD, '0, '0, 30'd1, '0, '0);
    push_packet_op(dpfrc_pkg::ACT_COUNT, '0, '0, '0, '0, TS_MAX);
    push_packet_op(dpfrc_pkg::ACT_COUNT, '0, '0, '0, 30'd1, 30'd1);
    push_packet_op(dpfrc_pkg::ACT_COUNT, '0, '0, '0, 30'd5, 30'd2);
    push_packet_op(dpfrc_pkg::ACT_COUNT, '0, '1, '0, TS_MAX, TS_MAX);
    push_packet_op(dpfrc_pkg::ACT_FORWARD, '0, '0, '0, '0, '0);
    // limit below occupancy: one eviction per add
    push_limit_write(5'd2);
    push_packet_op(dpfrc_pkg::ACT_ADD, 16'd7, 16'd7, 30'd7, '0, '0);
    push_packet_op(dpfrc_pkg::ACT_COUNT, '0, '0, '0, '0, TS_MAX);
    push_packet_op(dpfrc_pkg::ACT_FORWARD, '0, '0, '0, '0, '0);
    push_packet_op(dpfrc_pkg::ACT_FORWARD, '0, '0, '0, '0, '0);
    push_packet_op(dpfrc_pkg::ACT_FORWARD, '0, '0, '0, '0, '0);
    // full at limit one: duplicate of the oldest is still rejected
    push_limit_write(5'd1);
    push_packet_op(dpfrc_pkg::ACT_ADD, 16'd7, 16'd7, 30'd7, '0, '0);
    push_packet_op(dpfrc_pkg::ACT_ADD, 16'd8, 16'd8, 30'd8, '0, '0);
    push_limit_write(5'd0);
    push_packet_op(dpfrc_pkg::ACT_ADD, 16'd9, 16'd9, 30'd9, '0, '0);
    push_packet_op(dpfrc_pkg::ACT_FORWARD, '0, '0, '0, '0, '0);
    push_packet_op(dpfrc_pkg::ACT_FORWARD, '0, '0, '0, '0, '0);
    push_limit_write(5'd31);
    push_packet_op(dpfrc_pkg::ACT_ADD, '0, '0, TS_MAX, '0, '0);

    for (int ph = 0; ph < 3; ph++) begin
      sender_gap = gaps[ph];
      for (int blk = 0; blk < 10; blk++) begin
        case ($urandom_range(5))
          0: lim = 5'd0;
          1: lim = 5'd1;
          2: lim = 5'd16;
          3: lim = 5'd31;
          4: lim = dpfrc_pkg::LIMIT_W'($urandom_range(15, 2));
          default: lim = dpfrc_pkg::LIMIT_W'($urandom_range(30, 17));
        endcase
        push_limit_write(lim);
        refill_pools();
        for (int k = 0; k < 63; k++)
          push_random_op();
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (packet_ops.size() != 0 || start || cfg_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/dpfrc_pkg.sv
hw/rtl/dedup_packet_fifo_with_range_count.sv
hw/rtl/dpfrc_checker.sv
verif/tb_dedup_packet_fifo_with_range_count.sv
